// ===== hw/rtl/btpc_pkg.sv =====
`default_nettype none

package btpc_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_SUB,
		ST_T_MUL,
		ST_T_DEN,
		ST_T_DIV0,
		ST_T_B5,
		ST_T_RND,
		ST_P_B6,
		ST_P_SQ,
		ST_P_SQS,
		ST_P_X1A,
		ST_P_X3,
		ST_P_AC1,
		ST_P_B3R,
		ST_P_X2B,
		ST_P_X3B,
		ST_P_X3C,
		ST_P_B4M,
		ST_P_B4,
		ST_P_B7M,
		ST_P_DIV0,
		ST_DIV,
		ST_DIV_FIX,
		ST_P_TT,
		ST_P_C1,
		ST_P_C2,
		ST_P_C3,
		ST_P_C4,
		ST_P_C5,
		ST_SAT,
		ST_FINISH
	} state_t;

	localparam logic CMD_TEMP = 1'b0;
	localparam logic CMD_PRES = 1'b1;

	localparam logic [1:0] CFG_AC1_AC3 = 2'd0;
	localparam logic [1:0] CFG_AC4_AC6 = 2'd1;
	localparam logic [1:0] CFG_B1_B2   = 2'd2;
	localparam logic [1:0] CFG_MC_MD   = 2'd3;

	localparam int VALUE_W = 18;

	localparam logic [31:0] B6_OFFSET  = 32'd4000;
	localparam logic [31:0] B4_BIAS    = 32'd32768;
	localparam logic [31:0] B7_SCALE   = 32'd50000;
	localparam logic [31:0] P_COEF_SQ  = 32'd3038;
	localparam logic [31:0] P_COEF_LIN = 32'(-7357);
	localparam logic [31:0] P_BIAS     = 32'd3791;
	localparam logic [31:0] T_ROUND    = 32'd8;
	localparam logic [31:0] ROUND_2    = 32'd2;

	localparam logic [4:0] DIV_LAST = 5'd31;

	function automatic logic [VALUE_W-1:0] sat18(input logic [31:0] v);
		logic [VALUE_W-1:0] r;
		if (v[31] && !(&v[30:VALUE_W-1])) begin
			r = {1'b1, {(VALUE_W-1){1'b0}}};
		end else if (!v[31] && (|v[30:VALUE_W-1])) begin
			r = {1'b0, {(VALUE_W-1){1'b1}}};
		end else begin
			r = v[VALUE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/baro_temp_pressure_compensation.sv =====
// Barometer temperature and pressure compensation, oversampling 0.
//
// Input channel s_axis: tdata carries the raw 16-bit reading, tuser says
// whether it is a temperature (0) or pressure (1) sample. Output channel
// m_axis: tdata carries the signed 18-bit result (0.1 degC or Pa,
// saturated), tuser carries the kind and the zero-divisor flag.
// Calibration words are written by the user over cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this.
// Each sample runs through a small sequencer driving one 32x32 multiplier,
// one 32-bit adder and a radix-2 divider that retires one quotient bit per
// cycle. A zero divisor skips the division and gives the result at once;
// otherwise the 32-step division dominates both temperature and pressure.
// s_axis_tready is high only while no sample is in work. A finished result
// sits in the output register; the next sample is taken while it waits,
// and the sequencer holds its next result until the register frees up.
// A zero divisor yields value 0 with the error flag; a temperature sample
// then leaves the stored B5 unchanged.
// Reset clears calibration, the stored B5 (so pressure before temperature
// uses B5 = 0) and the output valid flag.
`default_nettype none

module baro_temp_pressure_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] raw_sample
	input  wire logic        s_axis_tuser,  // [0] command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [17:0] value, [23:18] zero
	output logic [1:0]       m_axis_tuser   // [0] kind, [1] div_error
);

	btpc_pkg::state_t state_q, state_d;

	logic [47:0] cal0_q, cal1_q;
	logic [31:0] cal2_q, cal3_q;
	logic [31:0] b5_q;

	logic        cmd_q;
	logic [15:0] raw_q;
	logic [31:0] prod_q, t1_q, t3_q, b6_q, sq_q, b3_q, b4_q, q_q;
	logic        b7hi_q;

	logic [31:0] rem_q, quo_q, d_q;
	logic [4:0]  cnt_q;
	logic        neg_q;

	logic [17:0] res_val_q;
	logic        res_err_q;

	logic        out_valid_q, out_kind_q, out_err_q;
	logic [17:0] out_val_q;

	logic [31:0] mul_a, mul_b, mul_res;
	logic [31:0] add_a, add_b, add_res;
	logic        add_cin;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, md;
	logic [15:0] mc;
	logic [16:0] mc_mag;
	logic [31:0] num_mag;

	logic [31:0] prod_sr11, prod_sr12, prod_sr13, prod_sr15, prod_sr16;
	logic [31:0] t1_sr2, t1_sr4, t3_sr2, q_sr8;
	logic [32:0] div_trial;
	logic        out_free;

	assign ac1 = btpc_pkg::sx16(cal0_q[15:0]);
	assign ac2 = btpc_pkg::sx16(cal0_q[31:16]);
	assign ac3 = btpc_pkg::sx16(cal0_q[47:32]);
	assign ac4 = {16'b0, cal1_q[15:0]};
	assign ac5 = {16'b0, cal1_q[31:16]};
	assign ac6 = {16'b0, cal1_q[47:32]};
	assign b1  = btpc_pkg::sx16(cal2_q[15:0]);
	assign b2  = btpc_pkg::sx16(cal2_q[31:16]);
	assign mc  = cal3_q[15:0];
	assign md  = btpc_pkg::sx16(cal3_q[31:16]);

	assign mc_mag  = mc[15] ? 17'(~{1'b1, mc} + 17'd1) : {1'b0, mc};
	assign num_mag = {4'b0, mc_mag, 11'b0};

	assign prod_sr11 = 32'($signed(prod_q) >>> 11);
	assign prod_sr12 = 32'($signed(prod_q) >>> 12);
	assign prod_sr13 = 32'($signed(prod_q) >>> 13);
	assign prod_sr15 = 32'($signed(prod_q) >>> 15);
	assign prod_sr16 = 32'($signed(prod_q) >>> 16);
	assign t1_sr2    = 32'($signed(t1_q) >>> 2);
	assign t1_sr4    = 32'($signed(t1_q) >>> 4);
	assign t3_sr2    = 32'($signed(t3_q) >>> 2);
	assign q_sr8     = 32'($signed(q_q) >>> 8);

	assign mul_res   = mul_a * mul_b;
	assign add_res   = add_a + add_b + {31'b0, add_cin};
	assign div_trial = {rem_q, quo_q[31]} - {1'b0, d_q};

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == btpc_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_val_q};
	assign m_axis_tuser  = {out_err_q, out_kind_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			btpc_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (s_axis_tuser == btpc_pkg::CMD_PRES) ?
						btpc_pkg::ST_P_B6 : btpc_pkg::ST_T_SUB;
				end
			end
			btpc_pkg::ST_T_SUB: begin
				add_a   = {16'b0, raw_q};
				add_b   = ~ac6;
				add_cin = 1'b1;
				state_d = btpc_pkg::ST_T_MUL;
			end
			btpc_pkg::ST_T_MUL: begin
				mul_a   = t1_q;
				mul_b   = ac5;
				state_d = btpc_pkg::ST_T_DEN;
			end
			btpc_pkg::ST_T_DEN: begin
				add_a   = prod_sr15;
				add_b   = md;
				state_d = btpc_pkg::ST_T_DIV0;
			end
			btpc_pkg::ST_T_DIV0: begin
				add_a   = t1_q[31] ? ~t1_q : t1_q;
				add_cin = t1_q[31];
				state_d = (t1_q == '0) ? btpc_pkg::ST_FINISH : btpc_pkg::ST_DIV;
			end
			btpc_pkg::ST_T_B5: begin
				add_a   = t3_q;
				add_b   = q_q;
				state_d = btpc_pkg::ST_T_RND;
			end
			btpc_pkg::ST_T_RND: begin
				add_a   = b5_q;
				add_b   = btpc_pkg::T_ROUND;
				state_d = btpc_pkg::ST_SAT;
			end
			btpc_pkg::ST_P_B6: begin
				add_a   = b5_q;
				add_b   = ~btpc_pkg::B6_OFFSET;
				add_cin = 1'b1;
				state_d = btpc_pkg::ST_P_SQ;
			end
			btpc_pkg::ST_P_SQ: begin
				mul_a   = b6_q;
				mul_b   = b6_q;
				state_d = btpc_pkg::ST_P_SQS;
			end
			btpc_pkg::ST_P_SQS: begin
				mul_a   = ac2;
				mul_b   = b6_q;
				state_d = btpc_pkg::ST_P_X1A;
			end
			btpc_pkg::ST_P_X1A: begin
				mul_a   = b2;
				mul_b   = sq_q;
				state_d = btpc_pkg::ST_P_X3;
			end
			btpc_pkg::ST_P_X3: begin
				add_a   = prod_sr11;
				add_b   = t1_q;
				mul_a   = ac3;
				mul_b   = b6_q;
				state_d = btpc_pkg::ST_P_AC1;
			end
			btpc_pkg::ST_P_AC1: begin
				add_a   = {ac1[29:0], 2'b0};
				add_b   = t1_q;
				mul_a   = b1;
				mul_b   = sq_q;
				state_d = btpc_pkg::ST_P_B3R;
			end
			btpc_pkg::ST_P_B3R: begin
				add_a   = t1_q;
				add_b   = btpc_pkg::ROUND_2;
				state_d = btpc_pkg::ST_P_X2B;
			end
			btpc_pkg::ST_P_X2B: begin
				add_a   = t3_q;
				add_b   = prod_sr16;
				state_d = btpc_pkg::ST_P_X3B;
			end
			btpc_pkg::ST_P_X3B: begin
				add_a   = t3_q;
				add_b   = btpc_pkg::ROUND_2;
				state_d = btpc_pkg::ST_P_X3C;
			end
			btpc_pkg::ST_P_X3C: begin
				add_a   = t3_sr2;
				add_b   = btpc_pkg::B4_BIAS;
				state_d = btpc_pkg::ST_P_B4M;
			end
			btpc_pkg::ST_P_B4M: begin
				mul_a   = ac4;
				mul_b   = t3_q;
				state_d = btpc_pkg::ST_P_B4;
			end
			btpc_pkg::ST_P_B4: begin
				add_a   = {16'b0, raw_q};
				add_b   = ~b3_q;
				add_cin = 1'b1;
				state_d = btpc_pkg::ST_P_B7M;
			end
			btpc_pkg::ST_P_B7M: begin
				mul_a   = t1_q;
				mul_b   = btpc_pkg::B7_SCALE;
				state_d = btpc_pkg::ST_P_DIV0;
			end
			btpc_pkg::ST_P_DIV0: begin
				state_d = (b4_q == '0) ? btpc_pkg::ST_FINISH : btpc_pkg::ST_DIV;
			end
			btpc_pkg::ST_DIV: begin
				if (cnt_q == btpc_pkg::DIV_LAST) begin
					state_d = btpc_pkg::ST_DIV_FIX;
				end
			end
			btpc_pkg::ST_DIV_FIX: begin
				add_a   = neg_q ? ~quo_q : quo_q;
				add_cin = neg_q;
				state_d = (cmd_q == btpc_pkg::CMD_PRES) ?
					btpc_pkg::ST_P_TT : btpc_pkg::ST_T_B5;
			end
			btpc_pkg::ST_P_TT: begin
				mul_a   = q_sr8;
				mul_b   = q_sr8;
				state_d = btpc_pkg::ST_P_C1;
			end
			btpc_pkg::ST_P_C1: begin
				mul_a   = prod_q;
				mul_b   = btpc_pkg::P_COEF_SQ;
				state_d = btpc_pkg::ST_P_C2;
			end
			btpc_pkg::ST_P_C2: begin
				mul_a   = q_q;
				mul_b   = btpc_pkg::P_COEF_LIN;
				state_d = btpc_pkg::ST_P_C3;
			end
			btpc_pkg::ST_P_C3: begin
				add_a   = t1_q;
				add_b   = prod_sr16;
				state_d = btpc_pkg::ST_P_C4;
			end
			btpc_pkg::ST_P_C4: begin
				add_a   = t1_q;
				add_b   = btpc_pkg::P_BIAS;
				state_d = btpc_pkg::ST_P_C5;
			end
			btpc_pkg::ST_P_C5: begin
				add_a   = q_q;
				add_b   = t1_sr4;
				state_d = btpc_pkg::ST_SAT;
			end
			btpc_pkg::ST_SAT: begin
				state_d = btpc_pkg::ST_FINISH;
			end
			btpc_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = btpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = btpc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal0_q <= '0;
			cal1_q <= '0;
			cal2_q <= '0;
			cal3_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				btpc_pkg::CFG_AC1_AC3: cal0_q <= cfg_data;
				btpc_pkg::CFG_AC4_AC6: cal1_q <= cfg_data;
				btpc_pkg::CFG_B1_B2:   cal2_q <= cfg_data[31:0];
				btpc_pkg::CFG_MC_MD:   cal3_q <= cfg_data[31:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q <= '0;
		end else if (state_q == btpc_pkg::ST_T_B5) begin
			b5_q <= add_res;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			btpc_pkg::ST_IDLE: begin
				cmd_q <= s_axis_tuser;
				raw_q <= s_axis_tdata;
			end
			btpc_pkg::ST_T_SUB: t1_q <= add_res;
			btpc_pkg::ST_T_MUL: prod_q <= mul_res;
			btpc_pkg::ST_T_DEN: begin
				t3_q <= prod_sr15;
				t1_q <= add_res;
			end
			btpc_pkg::ST_T_DIV0: begin
				quo_q <= num_mag;
				d_q   <= add_res;
				rem_q <= '0;
				cnt_q <= '0;
				neg_q <= mc[15] ^ t1_q[31];
			end
			btpc_pkg::ST_T_RND: t1_q <= add_res;
			btpc_pkg::ST_P_B6:  b6_q <= add_res;
			btpc_pkg::ST_P_SQ:  prod_q <= mul_res;
			btpc_pkg::ST_P_SQS: begin
				sq_q   <= prod_sr12;
				prod_q <= mul_res;
			end
			btpc_pkg::ST_P_X1A: begin
				t1_q   <= prod_sr11;
				prod_q <= mul_res;
			end
			btpc_pkg::ST_P_X3: begin
				t1_q   <= add_res;
				prod_q <= mul_res;
			end
			btpc_pkg::ST_P_AC1: begin
				t1_q   <= add_res;
				t3_q   <= prod_sr13;
				prod_q <= mul_res;
			end
			btpc_pkg::ST_P_B3R: t1_q <= add_res;
			btpc_pkg::ST_P_X2B: begin
				t3_q <= add_res;
				b3_q <= t1_sr2;
			end
			btpc_pkg::ST_P_X3B: t3_q <= add_res;
			btpc_pkg::ST_P_X3C: t3_q <= add_res;
			btpc_pkg::ST_P_B4M: prod_q <= mul_res;
			btpc_pkg::ST_P_B4: begin
				b4_q <= {15'b0, prod_q[31:15]};
				t1_q <= add_res;
			end
			btpc_pkg::ST_P_B7M: prod_q <= mul_res;
			btpc_pkg::ST_P_DIV0: begin
				quo_q  <= prod_q[31] ? prod_q : {prod_q[30:0], 1'b0};
				d_q    <= b4_q;
				rem_q  <= '0;
				cnt_q  <= '0;
				neg_q  <= 1'b0;
				b7hi_q <= prod_q[31];
			end
			btpc_pkg::ST_DIV: begin
				if (!div_trial[32]) begin
					rem_q <= div_trial[31:0];
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
				end
				quo_q <= {quo_q[30:0], !div_trial[32]};
				cnt_q <= cnt_q + 5'd1;
			end
			btpc_pkg::ST_DIV_FIX: begin
				if (cmd_q == btpc_pkg::CMD_PRES) begin
					q_q <= b7hi_q ? {quo_q[30:0], 1'b0} : quo_q;
				end else begin
					q_q <= add_res;
				end
			end
			btpc_pkg::ST_P_TT: prod_q <= mul_res;
			btpc_pkg::ST_P_C1: prod_q <= mul_res;
			btpc_pkg::ST_P_C2: begin
				t1_q   <= prod_sr16;
				prod_q <= mul_res;
			end
			btpc_pkg::ST_P_C3: t1_q <= add_res;
			btpc_pkg::ST_P_C4: t1_q <= add_res;
			btpc_pkg::ST_P_C5: t1_q <= add_res;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == btpc_pkg::ST_T_DIV0 && t1_q == '0) ||
			(state_q == btpc_pkg::ST_P_DIV0 && b4_q == '0)) begin
			res_val_q <= '0;
			res_err_q <= 1'b1;
		end else if (state_q == btpc_pkg::ST_SAT) begin
			res_val_q <= btpc_pkg::sat18((cmd_q == btpc_pkg::CMD_PRES) ? t1_q : t1_sr4);
			res_err_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == btpc_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == btpc_pkg::ST_FINISH && out_free) begin
			out_kind_q <= cmd_q;
			out_val_q  <= res_val_q;
			out_err_q  <= res_err_q;
		end
	end

endmodule

`default_nettype wire
